@@ src/lfps_pkg.sv @@
// Shared types and constants for the line-follow PID steering core.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package lfps_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_PROP   = 2'd1;
  localparam logic [1:0] REG_INTEG  = 2'd2;
  localparam logic [1:0] REG_DERIV  = 2'd3;

  // Reset values of the registers
  localparam logic [9:0]  TARGET_RST = 10'd512;
  localparam logic [31:0] PROP_RST   = 32'd123815854;
  localparam logic [31:0] INTEG_RST  = 32'd39;
  localparam logic [31:0] DERIV_RST  = 32'd749312410;

  // Arithmetic constants
  localparam logic [10:0] FULL_SCALE = 11'd1023;
  localparam logic [6:0]  STEER_MAX  = 7'd120;
  localparam int          FRAC_BITS  = 24;
  localparam logic [50:0] TERM_CAP   = {1'b1, 50'b0};
  localparam int          TOTAL_W    = 53;

  // Stage 1: error terms
  typedef struct packed {
    logic signed [10:0] err;
    logic signed [31:0] sum;
    logic signed [11:0] diff;
  } lfps_err_t;

  // Stage 2: product magnitudes with signs
  typedef struct packed {
    logic [41:0] p_mag;
    logic        p_neg;
    logic [63:0] i_mag;
    logic        i_neg;
    logic [42:0] d_mag;
    logic        d_neg;
  } lfps_prod_t;

endpackage

@@ src/line_follow_pid_steering_core.sv @@
// Line-follow PID steering core: top level, configuration registers and
// pipeline control. Depends on lfps_pkg, lfps_front, lfps_mult, lfps_sum.
//
// Usage:
//   Input channel in_valid/in_ready carries one light_raw sample a beat.
//   Output channel out_valid/out_ready carries one steering command for
//   every input beat, in order.
//   Configuration channel cfg_valid/cfg_ready writes cfg_data into the
//   register named by cfg_index (0 target, 1 P gain, 2 I gain, 3 D gain);
//   it is always ready. Write only while no beats are in flight.
// Timing:
//   Four-stage pipeline (error/integrator, multiply, sum, truncate/clamp).
//   A taken beat is registered in err_q, prod_q, total and steering in
//   turn; one beat per cycle is sustained while out_ready stays high.
//   The pipeline advances as a whole; when out_ready is low with a result
//   held, in_ready drops and every stage holds.
// Reset:
//   rst clears the pipeline, the error sum and the previous error, and
//   loads the register reset values (target 512, gains about 7.38,
//   0.0000023 and 44.66 in Q8.24).
`timescale 1ns / 1ps

module line_follow_pid_steering_core import lfps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [9:0]        light_raw,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] steering,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  logic [9:0]  target_level;
  logic [31:0] prop_gain;
  logic [31:0] integ_gain;
  logic [31:0] deriv_gain;
  logic        advance;
  logic        in_accept;
  logic        v1;
  logic        v2;
  logic        v3;
  lfps_err_t   err_s1;
  lfps_prod_t  prod_s2;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign in_accept = in_valid && advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= TARGET_RST;
      prop_gain    <= PROP_RST;
      integ_gain   <= INTEG_RST;
      deriv_gain   <= DERIV_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET: target_level <= cfg_data[9:0];
        REG_PROP:   prop_gain    <= cfg_data;
        REG_INTEG:  integ_gain   <= cfg_data;
        REG_DERIV:  deriv_gain   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_accept;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  lfps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .light_raw    (light_raw),
    .target_level (target_level),
    .err_q        (err_s1)
  );

  lfps_mult u_mult (
    .clk        (clk),
    .en         (advance),
    .err_in     (err_s1),
    .prop_gain  (prop_gain),
    .integ_gain (integ_gain),
    .deriv_gain (deriv_gain),
    .prod_q     (prod_s2)
  );

  lfps_sum u_sum (
    .clk      (clk),
    .en       (advance),
    .prod_in  (prod_s2),
    .steering (steering)
  );

  // Delivered command stays inside the clamp range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (steering <= 8'sd120) && (steering >= -8'sd120))
    else $error("steering outside clamp range");

  // Reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !v1 && !v2 && !v3 && !out_valid)
    else $error("pipeline not empty after reset");

  // An accepted beat reaches the output once the later stages advance without a stall
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_accept ##1 advance ##1 advance ##1 advance |=> out_valid)
    else $error("accepted beat lost in pipeline");

endmodule

@@ src/lfps_front.sv @@
// Error, saturating integrator and difference stage.
// Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_front import lfps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [9:0]  light_raw,
  input  logic [9:0]  target_level,
  output lfps_err_t   err_q
);

  logic [10:0]        err_u;
  logic signed [10:0] err;
  logic signed [32:0] sum_wide;
  logic signed [31:0] error_sum;
  logic signed [31:0] error_sum_next;
  logic signed [10:0] previous_error;
  logic signed [11:0] diff;

  // err = target - (1023 - raw); modular in 11 bits, true value always fits
  assign err_u = 11'(target_level) + 11'(light_raw) - FULL_SCALE;
  assign err   = $signed(err_u);

  // Integrator with saturation at the 32-bit limits
  always_comb begin
    sum_wide = {error_sum[31], error_sum} + {{22{err[10]}}, err};
    if (sum_wide[32] != sum_wide[31]) begin
      error_sum_next = sum_wide[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      error_sum_next = sum_wide[31:0];
    end
  end

  assign diff = {err[10], err} - {previous_error[10], previous_error};

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (accept) begin
      error_sum      <= error_sum_next;
      previous_error <= err;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (accept) begin
      err_q.err  <= err;
      err_q.sum  <= error_sum_next;
      err_q.diff <= diff;
    end
  end

  // State only moves on an accepted beat
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(error_sum) && $stable(previous_error))
    else $error("controller state changed without a beat");

  // Stored previous error is the error of the last beat
  a_prev_err: assert property (@(posedge clk) disable iff (rst)
    accept |=> previous_error == err_q.err)
    else $error("previous error does not track stage register");

endmodule

@@ src/lfps_mult.sv @@
// Gain multiply stage: three unsigned magnitude products with signs.
// Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_mult import lfps_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  lfps_err_t   err_in,
  input  logic [31:0] prop_gain,
  input  logic [31:0] integ_gain,
  input  logic [31:0] deriv_gain,
  output lfps_prod_t  prod_q
);

  logic [10:0] err_neg;
  logic [11:0] diff_neg;
  logic [9:0]  err_mag;
  logic [10:0] diff_mag;
  logic [31:0] sum_mag;

  // Magnitudes of the signed operands
  assign err_neg  = 11'(-err_in.err);
  assign diff_neg = 12'(-err_in.diff);
  assign err_mag  = err_in.err[10] ? err_neg[9:0] : err_in.err[9:0];
  assign diff_mag = err_in.diff[11] ? diff_neg[10:0] : err_in.diff[10:0];
  assign sum_mag  = err_in.sum[31] ? (~err_in.sum + 32'd1) : err_in.sum;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q.p_mag <= 42'(prop_gain) * 42'(err_mag);
      prod_q.p_neg <= err_in.err[10];
      prod_q.i_mag <= 64'(integ_gain) * 64'(sum_mag);
      prod_q.i_neg <= err_in.sum[31];
      prod_q.d_mag <= 43'(deriv_gain) * 43'(diff_mag);
      prod_q.d_neg <= err_in.diff[11];
    end
  end

endmodule

@@ src/lfps_sum.sv @@
// Term sum, truncation toward zero and clamp to the steering range.
// Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_sum import lfps_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  lfps_prod_t        prod_in,
  output logic signed [7:0] steering
);

  logic [50:0]               i_cap;
  logic signed [TOTAL_W-1:0] tp;
  logic signed [TOTAL_W-1:0] ti;
  logic signed [TOTAL_W-1:0] td;
  logic signed [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0]        total_mag;
  logic [TOTAL_W-FRAC_BITS-1:0] whole;
  logic [6:0]                steer_mag;
  logic [7:0]                steer_ext;

  // Integral term is capped at 2^50 before summing
  assign i_cap = (prod_in.i_mag > 64'(TERM_CAP)) ? TERM_CAP : prod_in.i_mag[50:0];

  // Signed terms and their sum
  always_comb begin
    tp = $signed(TOTAL_W'(prod_in.p_mag));
    ti = $signed(TOTAL_W'(i_cap));
    td = $signed(TOTAL_W'(prod_in.d_mag));
    if (prod_in.p_neg) tp = -tp;
    if (prod_in.i_neg) ti = -ti;
    if (prod_in.d_neg) td = -td;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total <= tp + ti + td;
    end
  end

  // Truncate toward zero via magnitude, then clamp
  assign total_mag = total[TOTAL_W-1] ? TOTAL_W'(-total) : total;
  assign whole     = total_mag[TOTAL_W-1:FRAC_BITS];
  assign steer_mag = (whole > (TOTAL_W-FRAC_BITS)'(STEER_MAX)) ? STEER_MAX : whole[6:0];
  assign steer_ext = total[TOTAL_W-1] ? 8'(-{1'b0, steer_mag}) : {1'b0, steer_mag};

  always_ff @(posedge clk) begin
    if (en) begin
      steering <= $signed(steer_ext);
    end
  end

endmodule
